>>> rtl/assert_macros.svh
// Assertion macros used by the checker file of the smoothing block.
// Each macro samples on clk and names the property under the given label.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define GBST_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("gbst assertion failed");

// Checked at every edge, reset included.
`define GBST_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("gbst assertion failed during or after reset");

`endif

>>> rtl/gbst_pkg.sv
// Shared types, widths and constants of the binary Gaussian smoothing block.
// No dependencies; imported by every module of the block.
package gbst_pkg;

  localparam int RAD_W       = 2;
  localparam int RAD_MAX     = 3;
  localparam int WEIGHT_W    = 16;
  localparam int THR_W       = 19;
  localparam int SUM_W       = 19;
  localparam int PEND_W      = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 19;
  localparam int DEFAULT_MAX_RADIUS = 3;

  localparam logic [RAD_W-1:0]    RST_RADIUS    = RAD_W'(1);
  localparam logic [THR_W-1:0]    RST_THRESHOLD = THR_W'(32768);
  localparam logic [WEIGHT_W-1:0] RST_W_CENTER  = WEIGHT_W'(32768);
  localparam logic [WEIGHT_W-1:0] RST_W_ONE     = WEIGHT_W'(16384);
  localparam logic [WEIGHT_W-1:0] RST_W_TWO     = WEIGHT_W'(0);
  localparam logic [WEIGHT_W-1:0] RST_W_THREE   = WEIGHT_W'(0);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS      = 3'd0,
    CFG_THRESHOLD   = 3'd1,
    CFG_W_CENTER    = 3'd2,
    CFG_W_DIST_ONE  = 3'd3,
    CFG_W_DIST_TWO  = 3'd4,
    CFG_W_DIST_THREE = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [RAD_W-1:0]    radius;
    logic [THR_W-1:0]    threshold;
    logic [WEIGHT_W-1:0] w_center;
    logic [WEIGHT_W-1:0] w_one;
    logic [WEIGHT_W-1:0] w_two;
    logic [WEIGHT_W-1:0] w_three;
  } cfg_t;

  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic             end_flag;
  } snap_t;

  typedef enum logic {
    ST_STREAM = 1'b0,
    ST_FLUSH  = 1'b1
  } win_state_t;

endpackage

>>> rtl/gbst_cfg.sv
// Configuration register file of the smoothing block.
// Depends on gbst_pkg for the register indexes, reset values and cfg_t.
module gbst_cfg import gbst_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radius    <= RST_RADIUS;
      cfg_r.threshold <= RST_THRESHOLD;
      cfg_r.w_center  <= RST_W_CENTER;
      cfg_r.w_one     <= RST_W_ONE;
      cfg_r.w_two     <= RST_W_TWO;
      cfg_r.w_three   <= RST_W_THREE;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_RADIUS:       cfg_r.radius    <= cfg_data[RAD_W-1:0];
        CFG_THRESHOLD:    cfg_r.threshold <= cfg_data[THR_W-1:0];
        CFG_W_CENTER:     cfg_r.w_center  <= cfg_data[WEIGHT_W-1:0];
        CFG_W_DIST_ONE:   cfg_r.w_one     <= cfg_data[WEIGHT_W-1:0];
        CFG_W_DIST_TWO:   cfg_r.w_two     <= cfg_data[WEIGHT_W-1:0];
        CFG_W_DIST_THREE: cfg_r.w_three   <= cfg_data[WEIGHT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

>>> rtl/gbst_window.sv
// Bit window, vector sequencer and snapshot register of the smoothing block.
// Depends on gbst_pkg; feeds gbst_judge with one window snapshot per result.
module gbst_window import gbst_pkg::*; #(
  parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [RAD_W-1:0]      cfg_radius,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_bit,
  input  logic                  in_end,
  input  logic                  judge_ready,
  output logic                  snap_valid,
  output logic [2*MAX_RADIUS:0] snap_win,
  output snap_t                 snap_ctl
);

  localparam int WIN_W = 2 * MAX_RADIUS + 1;
  localparam logic [RAD_W-1:0] RAD_CAP =
    RAD_W'((MAX_RADIUS < RAD_MAX) ? MAX_RADIUS : RAD_MAX);
  localparam logic [PEND_W-1:0] PEND_SAT = '1;

  win_state_t        state_r, state_nxt;
  logic [WIN_W-1:0]  win_r, win_nxt, win_step;
  logic [PEND_W-1:0] pend_r, pend_nxt, pend_inc;
  logic [RAD_W-1:0]  lead_r, lead_nxt, r_raw, r_cur;
  logic [RAD_W-1:0]  s_r, s_nxt;
  logic              snap_valid_r, snap_valid_nxt;
  logic [WIN_W-1:0]  snap_win_r;
  snap_t             snap_ctl_r;
  logic              adv, step_go, emit, end_flag;

  assign adv      = !snap_valid_r || judge_ready;
  assign r_raw    = (pend_r == '0) ? cfg_radius : lead_r;
  assign r_cur    = (r_raw > RAD_CAP) ? RAD_CAP : r_raw;
  assign pend_inc = (pend_r == PEND_SAT) ? pend_r : pend_r + PEND_W'(1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_STREAM: begin
        if (adv && in_valid && in_end && (r_cur != '0)) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (adv && (s_r == r_cur)) begin
          state_nxt = ST_STREAM;
        end
      end
      default: state_nxt = ST_STREAM;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    step_go  = 1'b0;
    win_step = win_r;
    emit     = 1'b0;
    end_flag = 1'b0;
    win_nxt  = win_r;
    pend_nxt = pend_r;
    lead_nxt = lead_r;
    s_nxt    = s_r;
    unique case (state_r)
      ST_STREAM: begin
        in_ready = adv;
        step_go  = adv && in_valid;
        win_step = {win_r[WIN_W-2:0], in_bit};
        emit     = pend_inc > {1'b0, r_cur};
        end_flag = in_end && (r_cur == '0);
        s_nxt    = RAD_W'(1);
        if (step_go) begin
          if (end_flag) begin
            win_nxt  = '0;
            pend_nxt = '0;
            lead_nxt = '0;
          end else begin
            win_nxt  = win_step;
            pend_nxt = pend_inc;
            lead_nxt = r_raw;
          end
        end
      end
      ST_FLUSH: begin
        step_go  = adv;
        win_step = {win_r[WIN_W-2:0], 1'b0};
        emit     = ({1'b0, pend_r} + {2'b00, s_r}) > {2'b00, r_cur};
        end_flag = (s_r == r_cur);
        if (step_go) begin
          if (end_flag) begin
            win_nxt  = '0;
            pend_nxt = '0;
            lead_nxt = '0;
          end else begin
            win_nxt = win_step;
            s_nxt   = s_r + RAD_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
    snap_valid_nxt = adv ? (step_go && emit) : snap_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_STREAM;
      win_r        <= '0;
      pend_r       <= '0;
      lead_r       <= '0;
      s_r          <= '0;
      snap_valid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      win_r        <= win_nxt;
      pend_r       <= pend_nxt;
      lead_r       <= lead_nxt;
      s_r          <= s_nxt;
      snap_valid_r <= snap_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      snap_win_r          <= win_step;
      snap_ctl_r.rad      <= r_cur;
      snap_ctl_r.end_flag <= end_flag;
    end
  end

  assign snap_valid = snap_valid_r;
  assign snap_win   = snap_win_r;
  assign snap_ctl   = snap_ctl_r;

endmodule

>>> rtl/gbst_judge.sv
// Weighted window sum, threshold compare and result register.
// Depends on gbst_pkg; takes snapshots from gbst_window.
module gbst_judge import gbst_pkg::*; #(
  parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_t                  cfg,
  input  logic                  snap_valid,
  input  logic [2*MAX_RADIUS:0] snap_win,
  input  snap_t                 snap_ctl,
  output logic                  judge_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_bit,
  output logic                  out_end
);

  localparam int WIN_W = 2 * MAX_RADIUS + 1;
  localparam int TAPS  = (WIN_W < 2 * RAD_MAX + 1) ? WIN_W : 2 * RAD_MAX + 1;

  logic [SUM_W-1:0] sum;
  logic             hit;
  logic             out_valid_r;
  logic             out_bit_r, out_end_r;

  always_comb begin : judge_sum
    logic [2:0]          kk;
    logic [2:0]          gap;
    logic [WEIGHT_W-1:0] w;
    sum = '0;
    for (int k = 0; k < TAPS; k++) begin
      kk = 3'(k);
      if (kk > {1'b0, snap_ctl.rad}) begin
        gap = kk - {1'b0, snap_ctl.rad};
      end else begin
        gap = {1'b0, snap_ctl.rad} - kk;
      end
      unique case (gap)
        3'd0:    w = cfg.w_center;
        3'd1:    w = cfg.w_one;
        3'd2:    w = cfg.w_two;
        3'd3:    w = cfg.w_three;
        default: w = '0;
      endcase
      if (snap_win[k] && (kk <= {snap_ctl.rad, 1'b0})) begin
        sum = sum + SUM_W'(w);
      end
    end
  end

  assign hit         = sum > cfg.threshold;
  assign judge_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (judge_ready) begin
      out_valid_r <= snap_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (judge_ready && snap_valid) begin
      out_bit_r <= hit;
      out_end_r <= snap_ctl.end_flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_bit   = out_bit_r;
  assign out_end   = out_end_r;

endmodule

>>> rtl/binary_gaussian_smooth_threshold.sv
// Channel  Handshake               Payload
// in       in_valid / in_ready     in_bit_in, in_vector_end
// out      out_valid / out_ready   out_bit_out, out_out_end
// cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
// The window snapshot register loads at the edge that accepts a bit, and the
// adder tree and threshold compare load the result register from it when the
// result register is free. One bit is accepted per cycle while the output is
// not stalled; a last bit holds the input while the window shifts out the
// remaining results. Reset is synchronous; a stalled output backs up into
// the snapshot register and then the input.
// Top level of the binary Gaussian smoothing and threshold block.
// Depends on gbst_pkg, gbst_cfg, gbst_window and gbst_judge.
module binary_gaussian_smooth_threshold import gbst_pkg::*; #(
  parameter int MAX_RADIUS = DEFAULT_MAX_RADIUS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_bit_in,
  input  logic                  in_vector_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_bit_out,
  output logic                  out_out_end,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t                  cfg;
  logic                  judge_ready;
  logic                  snap_valid;
  logic [2*MAX_RADIUS:0] snap_win;
  snap_t                 snap_ctl;

  assign cfg_ready = 1'b1;

  gbst_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  gbst_window #(.MAX_RADIUS(MAX_RADIUS)) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_radius  (cfg.radius),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_bit      (in_bit_in),
    .in_end      (in_vector_end),
    .judge_ready (judge_ready),
    .snap_valid  (snap_valid),
    .snap_win    (snap_win),
    .snap_ctl    (snap_ctl)
  );

  gbst_judge #(.MAX_RADIUS(MAX_RADIUS)) u_judge (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .snap_valid  (snap_valid),
    .snap_win    (snap_win),
    .snap_ctl    (snap_ctl),
    .judge_ready (judge_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_bit     (out_bit_out),
    .out_end     (out_out_end)
  );

endmodule

>>> rtl/gbst_checker.sv
// Port-level checker for the smoothing block, bound to its top level.
// Depends on the macros in assert_macros.svh and the ports of the top level.
`include "assert_macros.svh"

module gbst_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic in_bit_in,
  input logic in_vector_end,
  input logic out_valid,
  input logic out_ready,
  input logic out_bit_out,
  input logic out_out_end
);

  logic in_stall;
  logic out_stall;

  assign in_stall  = in_valid && !in_ready;
  assign out_stall = out_valid && !out_ready;

  // A result beat that is not taken keeps its payload.
  `GBST_ASSERT(a_out_hold, out_stall |=> out_valid && $stable(out_bit_out) && $stable(out_out_end))

  // An input beat that is not taken keeps its payload.
  `GBST_ASSERT(a_in_hold, in_stall |=> in_valid && $stable(in_bit_in) && $stable(in_vector_end))

  // A reset cycle leaves no result pending.
  `GBST_ASSERT_ALWAYS(a_rst_out, !rst_n |=> !out_valid)

  // After a bit that does not end its vector, input stalls only behind output.
  `GBST_ASSERT(a_in_flow, in_valid && in_ready && !in_vector_end |=> in_ready || out_stall)

endmodule

bind binary_gaussian_smooth_threshold gbst_checker u_gbst_checker (.*);
